// ===== rtl/fixed_frame_deframer_resync_defines.svh =====
// Assertion macros shared by the deframer RTL.
// Uses clk and rst_n of the including module; no other dependencies.
`ifndef FIXED_FRAME_DEFRAMER_RESYNC_DEFINES_SVH
`define FIXED_FRAME_DEFRAMER_RESYNC_DEFINES_SVH

// same-cycle implication
`define FDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/fdr_pkg.sv =====
// Shared types and constants for the fixed-length frame deframer.
// No dependencies.
`timescale 1ns / 1ps

package fdr_pkg;

  localparam int unsigned FRAME_BYTES_DEF = 64;

  localparam logic [7:0] HDR_AIM    = 8'h71;
  localparam logic [7:0] TAIL_AIM   = 8'h4C;
  localparam logic [7:0] HDR_NAV    = 8'h72;
  localparam logic [7:0] TAIL_NAV_A = 8'h21;
  localparam logic [7:0] TAIL_NAV_B = 8'h4D;

  localparam logic KIND_NAV = 1'b0;
  localparam logic KIND_AIM = 1'b1;

  // one output word
  typedef struct packed {
    logic [7:0] frame_byte;
    logic [5:0] byte_index;
    logic       frame_kind;
    logic       frame_last;
  } fdr_word_t;

  function automatic logic fdr_is_header(input logic [7:0] b);
    return (b == HDR_AIM) || (b == HDR_NAV);
  endfunction

endpackage

// ===== rtl/fdr_mem.sv =====
// Frame store: simple dual-port RAM, one write and one registered read port.
// Depends on nothing.
`timescale 1ns / 1ps

module fdr_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/fdr_out.sv =====
// Output register stage for the result stream.
// Depends on fdr_pkg (word type).
`timescale 1ns / 1ps

module fdr_out (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  fdr_pkg::fdr_word_t word_in,
  output logic              free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output fdr_pkg::fdr_word_t word_q
);

  import fdr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  fdr_word_t word_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign word_q     = word_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word_r <= word_in;
    end
  end

endmodule

// ===== rtl/fixed_frame_deframer_resync.sv =====
// Fixed-length frame deframer with header/tail check and resync. Bytes are taken one per
// cycle into a ring-addressed frame store until FRAME_BYTES are held. A valid frame is then
// read back through the store's single read port and sent one word per cycle while the
// output register is free; an invalid buffer is scanned for the next header, one entry per
// cycle, from position 1 through the last entry. No input is taken during send or scan; the
// output register lets the last word wait while the next byte comes in. Aim frames with
// aim_enable low are consumed in the byte's own cycle. No clearing pass after reset: only
// written entries are ever read.
`timescale 1ns / 1ps
`include "fixed_frame_deframer_resync_defines.svh"

module fixed_frame_deframer_resync #(
  parameter int unsigned FRAME_BYTES = fdr_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_wdata,   // aim_enable
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] frame_byte, [13:8] byte_index, [15:14] zero
  output logic        out_tuser,   // frame_kind
  output logic        out_tlast    // frame_last
);

  import fdr_pkg::*;

  localparam int unsigned AW   = $clog2(FRAME_BYTES);
  localparam logic [AW:0]   NW   = (AW+1)'(FRAME_BYTES);
  localparam logic [AW-1:0] LAST = AW'(FRAME_BYTES - 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EMIT = 3'b010,
    ST_SCAN = 3'b100
  } state_t;

  state_t        st_r, st_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] base_r, base_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          hunting_r, hunting_nxt;
  logic          aim_en_r, aim_en_nxt;
  logic [7:0]    head_r, head_nxt;
  logic          kind_r, kind_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]    mem_rdata;

  logic          acc, take, full, is_aim, is_nav, emit_go, load, out_free;
  fdr_word_t     word_in, word_q;

  // logical position -> store address
  function automatic logic [AW-1:0] ring(input logic [AW-1:0] b, input logic [AW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, o};
    if (s >= NW) begin
      s = s - NW;
    end
    return s[AW-1:0];
  endfunction

  assign in_tready = (st_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign take      = acc && (!hunting_r || fdr_is_header(in_tdata));
  assign full      = (fill_r == LAST);
  assign is_aim    = (head_r == HDR_AIM) && (in_tdata == TAIL_AIM);
  assign is_nav    = (head_r == HDR_NAV) &&
                     ((in_tdata == TAIL_NAV_A) || (in_tdata == TAIL_NAV_B));
  assign emit_go   = take && full && (is_nav || (is_aim && aim_en_r));

  assign mem_waddr = ring(base_r, fill_r);

  assign word_in.frame_byte = mem_rdata;
  assign word_in.byte_index = 6'(idx_r);
  assign word_in.frame_kind = kind_r;
  assign word_in.frame_last = (idx_r == LAST);

  always_comb begin
    st_nxt      = st_r;
    fill_nxt    = fill_r;
    base_nxt    = base_r;
    idx_nxt     = idx_r;
    hunting_nxt = hunting_r;
    aim_en_nxt  = cfg_we ? cfg_wdata : aim_en_r;
    head_nxt    = head_r;
    kind_nxt    = kind_r;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = base_r;
    load        = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (take) begin
          mem_we      = 1'b1;
          hunting_nxt = 1'b0;
          if (fill_r == '0) begin
            head_nxt = in_tdata;
          end
          if (!full) begin
            fill_nxt = fill_r + AW'(1);
          end else if (is_aim || is_nav) begin
            fill_nxt = '0;
            kind_nxt = is_aim ? KIND_AIM : KIND_NAV;
            if (emit_go) begin
              st_nxt    = ST_EMIT;
              idx_nxt   = '0;
              mem_re    = 1'b1;
              mem_raddr = base_r;
            end
          end else begin
            // look for the next header from position 1
            st_nxt    = ST_SCAN;
            idx_nxt   = AW'(1);
            mem_re    = 1'b1;
            mem_raddr = ring(base_r, AW'(1));
          end
        end
      end
      ST_EMIT: begin
        load = out_free;
        if (out_free) begin
          if (idx_r == LAST) begin
            st_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            mem_re    = 1'b1;
            mem_raddr = ring(base_r, idx_r + AW'(1));
          end
        end
      end
      ST_SCAN: begin
        if (fdr_is_header(mem_rdata)) begin
          base_nxt = ring(base_r, idx_r);
          fill_nxt = AW'(NW - {1'b0, idx_r});
          head_nxt = mem_rdata;
          st_nxt   = ST_IDLE;
        end else if (idx_r == LAST) begin
          fill_nxt    = '0;
          hunting_nxt = 1'b1;
          st_nxt      = ST_IDLE;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          mem_re    = 1'b1;
          mem_raddr = ring(base_r, idx_r + AW'(1));
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      fill_r    <= '0;
      base_r    <= '0;
      idx_r     <= '0;
      hunting_r <= 1'b0;
      aim_en_r  <= 1'b0;
    end else begin
      st_r      <= st_nxt;
      fill_r    <= fill_nxt;
      base_r    <= base_nxt;
      idx_r     <= idx_nxt;
      hunting_r <= hunting_nxt;
      aim_en_r  <= aim_en_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    kind_r <= kind_nxt;
  end

  fdr_mem #(
    .DEPTH (FRAME_BYTES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (in_tdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fdr_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .word_in    (word_in),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .word_q     (word_q)
  );

  assign out_tdata = {2'b00, word_q.byte_index, word_q.frame_byte};
  assign out_tuser = word_q.frame_kind;
  assign out_tlast = word_q.frame_last;

  `FDR_ASSERT_NOW(a_hunt_empty, hunting_r, fill_r == '0, "hunting with bytes held")
  `FDR_ASSERT_NOW(a_rw_apart, mem_we && mem_re, mem_waddr != mem_raddr,
                  "read and write hit the same entry")
  `FDR_ASSERT_NEXT(a_emit_blocks, emit_go, !in_tready, "input taken while frame pending")
  `FDR_ASSERT_NEXT(a_emit_done, (st_r == ST_EMIT) && load && (idx_r == LAST),
                   (st_r == ST_IDLE) && out_tvalid && out_tlast, "frame end not shown")

endmodule
